/* rtl/wrrb_pkg.sv */
// Shared types and constants for the wrapping record ring buffer.
// No dependencies; used by wrrb_space and wrapping_record_ring_buffer.
`default_nettype none

package wrrb_pkg;

   localparam int CMD_W    = 2;
   localparam int LEN_W    = 11;
   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 16;
   localparam int STATUS_W = 3;
   localparam int CAP_W    = 13;
   localparam int MAXREC_W = 17;

   // bytes of the little-endian length header in front of each record
   localparam int HEADER_LEN = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_START = 2'd0,
      CMD_WRITE_BYTE  = 2'd1,
      CMD_READ_START  = 2'd2,
      CMD_READ_BYTE   = 2'd3
   } command_type;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NO_ROOM   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_OVERSIZE  = 3'd4;
   localparam logic [STATUS_W-1:0] STS_IGNORED   = 3'd5;

endpackage

`default_nettype wire

/* rtl/wrrb_space.sv */
// Placement check for a new record: after the tail, or at offset 0 below the head.
// Depends on wrrb_pkg.
`default_nettype none

module wrrb_space #(
   parameter int PW = 13
) (
   input  wire logic [PW-1:0]                 head_offset,
   input  wire logic [PW-1:0]                 tail_offset,
   input  wire logic [PW-1:0]                 cap_used,
   input  wire logic [wrrb_pkg::LEN_W-1:0]    record_length,
   output logic                               ring_empty,
   output logic                               fits,
   output logic                               wraps,
   output logic [PW-1:0]                      base
);

   localparam int SW = ((PW > wrrb_pkg::CAP_W) ? PW : wrrb_pkg::CAP_W) + 1;

   logic [PW-1:0] head_n;
   logic [PW-1:0] tail_n;
   logic [SW-1:0] rec;
   logic [SW-1:0] tail_end;
   logic          wrapped;
   logic          at_tail;
   logic          after_wrap;

   always_comb begin
      // an empty ring restarts at offset 0
      ring_empty = (head_offset == tail_offset);
      head_n     = ring_empty ? '0 : head_offset;
      tail_n     = ring_empty ? '0 : tail_offset;
      rec        = SW'(wrrb_pkg::HEADER_LEN) + SW'(record_length);
      tail_end   = SW'(tail_n) + rec;
      wrapped    = (head_n > tail_n);
      if (wrapped) begin
         at_tail = (tail_end < SW'(head_n));
      end else begin
         at_tail = (tail_end <= SW'(cap_used));
      end
      after_wrap = !wrapped && (rec < SW'(head_n));
      fits       = at_tail || after_wrap;
      wraps      = !at_tail;
      base       = at_tail ? tail_n : '0;
   end

endmodule

`default_nettype wire

/* rtl/wrapping_record_ring_buffer.sv */
// Top level of the wrapping record ring buffer: control sequencer and byte ring memory.
// Depends on wrrb_pkg and wrrb_space.
`default_nettype none

// Variable-length records live in a byte ring, each behind a 2-byte little-endian
// length header and never split across the ring end. One command is processed at a
// time and every command returns exactly one response transfer. write_byte, and every
// command that is refused or ignored (oversize, no room, empty, stray byte), goes
// straight to the response state; an accepted write_start first writes the second
// header byte (the ring has one write port, so the two header bytes go in on
// consecutive cycles); a read_start that finds a record and an accepted read_byte
// first wait for the registered memory read. A stalled response holds back staging
// of the next one. A new command is accepted the cycle after the response is staged,
// even while the previous response is stalled. Writing capacity empties the ring and
// drops any unfinished read or write; there is no clearing pass after reset.
module wrapping_record_ring_buffer #(
   parameter int RING_BYTES = 4096,
   parameter int MAX_RECORD = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [wrrb_pkg::CMD_W-1:0]        req_command,
   input  wire logic [wrrb_pkg::LEN_W-1:0]        req_record_length,
   input  wire logic [wrrb_pkg::BYTE_W-1:0]       req_data_byte,
   input  wire logic [wrrb_pkg::LIMIT_W-1:0]      req_read_limit,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [wrrb_pkg::STATUS_W-1:0]          rsp_status,
   output logic [wrrb_pkg::LEN_W-1:0]             rsp_length_out,
   output logic [wrrb_pkg::BYTE_W-1:0]            rsp_byte_out,
   output logic                                   rsp_last_byte,
   input  wire logic                              csr_wr_en,
   input  wire logic [wrrb_pkg::CAP_W-1:0]        csr_wr_data
);

   localparam int PW = $clog2(RING_BYTES + 1);
   localparam int AW = $clog2(RING_BYTES);
   localparam int SW = ((PW > wrrb_pkg::CAP_W) ? PW : wrrb_pkg::CAP_W) + 1;
   localparam int LW = wrrb_pkg::LEN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_RHDR,
      S_RBYTE,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [wrrb_pkg::CAP_W-1:0] cap_ff;
   logic [PW-1:0] head_ff;
   logic [PW-1:0] tail_ff;
   logic [PW-1:0] wrap_ff;
   logic [PW-1:0] wcur_ff;
   logic [LW-1:0] wleft_ff;
   logic          wwraps_ff;
   logic [PW-1:0] rcur_ff;
   logic [LW-1:0] rleft_ff;

   logic [wrrb_pkg::CAP_W-1:0] cap_in;
   logic [PW-1:0] head_in;
   logic [PW-1:0] tail_in;
   logic [PW-1:0] wrap_in;
   logic [PW-1:0] wcur_in;
   logic [LW-1:0] wleft_in;
   logic          wwraps_in;
   logic [PW-1:0] rcur_in;
   logic [LW-1:0] rleft_in;

   logic [PW-1:0] hdr_addr_ff;
   logic [7:0]    hdr_byte_ff;
   logic [PW-1:0] rbase_ff;
   logic [wrrb_pkg::LIMIT_W-1:0] lim_ff;

   logic [PW-1:0] hdr_addr_in;
   logic [7:0]    hdr_byte_in;
   logic [PW-1:0] rbase_in;
   logic [wrrb_pkg::LIMIT_W-1:0] lim_in;

   logic [wrrb_pkg::STATUS_W-1:0] res_status_ff;
   logic [LW-1:0]                 res_len_ff;
   logic [wrrb_pkg::BYTE_W-1:0]   res_byte_ff;
   logic                          res_last_ff;
   logic                          rsp_valid_ff;

   logic [wrrb_pkg::STATUS_W-1:0] res_status_in;
   logic [LW-1:0]                 res_len_in;
   logic [wrrb_pkg::BYTE_W-1:0]   res_byte_in;
   logic                          res_last_in;
   logic                          rsp_valid_in;
   logic                          rsp_load;

   logic [7:0]    ring_mem [RING_BYTES];
   logic [7:0]    rd0_ff;
   logic [7:0]    rd1_ff;
   logic          rd0_ok_ff;
   logic          rd1_ok_ff;

   logic          accept;
   logic          oversize;
   logic [PW-1:0] cap_used;
   logic [PW-1:0] rd_base;
   logic [7:0]    rd0;
   logic [7:0]    rd1;
   logic [15:0]   rlen;

   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          rd_en;
   logic [PW-1:0] rd_addr0;
   logic [PW-1:0] rd_addr1;

   logic          sp_empty;
   logic          sp_fits;
   logic          sp_wraps;
   logic [PW-1:0] sp_base;

   function automatic logic [PW-1:0] cap_limit(input logic [wrrb_pkg::CAP_W-1:0] c);
      logic [SW-1:0] cw;
      cw = SW'(c);
      if (cw > SW'(RING_BYTES)) begin
         return PW'(RING_BYTES);
      end
      return cw[PW-1:0];
   endfunction

   wrrb_space #(
      .PW (PW)
   ) u_space (
      .head_offset   (head_ff),
      .tail_offset   (tail_ff),
      .cap_used      (cap_used),
      .record_length (req_record_length),
      .ring_empty    (sp_empty),
      .fits          (sp_fits),
      .wraps         (sp_wraps),
      .base          (sp_base)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign accept         = req_valid && !req_stall;
   assign cap_used       = cap_limit(cap_ff);
   assign oversize       = (wrrb_pkg::MAXREC_W'(req_record_length) >
                            wrrb_pkg::MAXREC_W'(MAX_RECORD));
   assign rd_base        = (head_ff >= wrap_ff) ? '0 : head_ff;
   assign rd0            = rd0_ok_ff ? rd0_ff : 8'd0;
   assign rd1            = rd1_ok_ff ? rd1_ff : 8'd0;
   assign rlen           = {rd1, rd0};

   assign rsp_valid      = rsp_valid_ff;

   // memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wcur_ff;
      mem_wdata = req_data_byte;
      rd_en     = 1'b0;
      rd_addr0  = rcur_ff;
      rd_addr1  = PW'(rcur_ff + 1'b1);
      if (state_ff == S_HDR) begin
         mem_we    = 1'b1;
         mem_waddr = hdr_addr_ff;
         mem_wdata = hdr_byte_ff;
      end else if (accept) begin
         case (wrrb_pkg::command_type'(req_command))
            wrrb_pkg::CMD_WRITE_START: begin
               if (!oversize && sp_fits) begin
                  mem_we    = 1'b1;
                  mem_waddr = sp_base;
                  mem_wdata = req_record_length[7:0];
               end
            end
            wrrb_pkg::CMD_WRITE_BYTE: begin
               mem_we = (wleft_ff != '0);
            end
            wrrb_pkg::CMD_READ_START: begin
               rd_en    = (head_ff != tail_ff);
               rd_addr0 = rd_base;
               rd_addr1 = PW'(rd_base + 1'b1);
            end
            wrrb_pkg::CMD_READ_BYTE: begin
               rd_en = (rleft_ff != '0);
            end
            default: begin
               rd_en = 1'b0;
            end
         endcase
      end
   end

   // byte ring: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we && (mem_waddr < PW'(RING_BYTES))) begin
         ring_mem[mem_waddr[AW-1:0]] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff    <= ring_mem[rd_addr0[AW-1:0]];
         rd1_ff    <= ring_mem[rd_addr1[AW-1:0]];
         rd0_ok_ff <= (rd_addr0 < PW'(RING_BYTES));
         rd1_ok_ff <= (rd_addr1 < PW'(RING_BYTES));
      end
   end

   // sequencer next values, ring pointers and response staging
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      wrap_in       = wrap_ff;
      wcur_in       = wcur_ff;
      wleft_in      = wleft_ff;
      wwraps_in     = wwraps_ff;
      rcur_in       = rcur_ff;
      rleft_in      = rleft_ff;
      hdr_addr_in   = hdr_addr_ff;
      hdr_byte_in   = hdr_byte_ff;
      rbase_in      = rbase_ff;
      lim_in        = lim_ff;
      res_status_in = res_status_ff;
      res_len_in    = res_len_ff;
      res_byte_in   = res_byte_ff;
      res_last_in   = res_last_ff;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = wrrb_pkg::STS_IGNORED;
               res_len_in    = '0;
               res_byte_in   = '0;
               res_last_in   = 1'b0;
               state_in      = S_RESP;
               case (wrrb_pkg::command_type'(req_command))
                  wrrb_pkg::CMD_WRITE_START: begin
                     wleft_in  = '0;
                     wwraps_in = 1'b0;
                     if (oversize) begin
                        res_status_in = wrrb_pkg::STS_OVERSIZE;
                     end else begin
                        if (sp_empty) begin
                           head_in = '0;
                           tail_in = '0;
                           wrap_in = cap_used;
                        end
                        if (sp_fits) begin
                           res_status_in = wrrb_pkg::STS_OK;
                           wwraps_in     = sp_wraps;
                           wcur_in       = PW'(sp_base + PW'(wrrb_pkg::HEADER_LEN));
                           wleft_in      = req_record_length;
                           hdr_addr_in   = PW'(sp_base + 1'b1);
                           hdr_byte_in   = 8'(req_record_length >> 8);
                           state_in      = S_HDR;
                           // empty record commits at once
                           if (req_record_length == '0) begin
                              if (sp_wraps) begin
                                 wrap_in = tail_ff;
                              end
                              tail_in   = PW'(sp_base + PW'(wrrb_pkg::HEADER_LEN));
                              wwraps_in = 1'b0;
                           end
                        end else begin
                           res_status_in = wrrb_pkg::STS_NO_ROOM;
                        end
                     end
                  end
                  wrrb_pkg::CMD_WRITE_BYTE: begin
                     if (wleft_ff != '0) begin
                        res_status_in = wrrb_pkg::STS_OK;
                        wcur_in       = PW'(wcur_ff + 1'b1);
                        wleft_in      = LW'(wleft_ff - 1'b1);
                        if (wleft_ff == LW'(1)) begin
                           if (wwraps_ff) begin
                              wrap_in = tail_ff;
                           end
                           tail_in   = PW'(wcur_ff + 1'b1);
                           wwraps_in = 1'b0;
                        end
                     end
                  end
                  wrrb_pkg::CMD_READ_START: begin
                     rleft_in = '0;
                     if (head_ff == tail_ff) begin
                        res_status_in = wrrb_pkg::STS_EMPTY;
                     end else begin
                        // consume the wrap mark
                        if (head_ff >= wrap_ff) begin
                           head_in = '0;
                           wrap_in = cap_used;
                        end
                        rbase_in = rd_base;
                        lim_in   = req_read_limit;
                        state_in = S_RHDR;
                     end
                  end
                  wrrb_pkg::CMD_READ_BYTE: begin
                     if (rleft_ff != '0) begin
                        res_status_in = wrrb_pkg::STS_OK;
                        rcur_in       = PW'(rcur_ff + 1'b1);
                        rleft_in      = LW'(rleft_ff - 1'b1);
                        state_in      = S_RBYTE;
                        if (rleft_ff == LW'(1)) begin
                           res_last_in = 1'b1;
                           head_in     = PW'(rcur_ff + 1'b1);
                        end
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_HDR: begin
            state_in = S_RESP;
         end
         S_RHDR: begin
            if (rlen > lim_ff) begin
               res_status_in = wrrb_pkg::STS_TOO_LARGE;
            end else begin
               res_status_in = wrrb_pkg::STS_OK;
               res_len_in    = rlen[LW-1:0];
               rcur_in       = PW'(rbase_ff + PW'(wrrb_pkg::HEADER_LEN));
               rleft_in      = rlen[LW-1:0];
               if (rlen == 16'd0) begin
                  head_in = PW'(rbase_ff + PW'(wrrb_pkg::HEADER_LEN));
               end
            end
            state_in = S_RESP;
         end
         S_RBYTE: begin
            res_byte_in = rd0;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write empties the ring
      if (csr_wr_en) begin
         cap_in    = csr_wr_data;
         head_in   = '0;
         tail_in   = '0;
         wrap_in   = cap_limit(csr_wr_data);
         wcur_in   = '0;
         wleft_in  = '0;
         wwraps_in = 1'b0;
         rcur_in   = '0;
         rleft_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= wrrb_pkg::CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         wrap_ff      <= cap_limit(wrrb_pkg::CAP_RESET);
         wcur_ff      <= '0;
         wleft_ff     <= '0;
         wwraps_ff    <= 1'b0;
         rcur_ff      <= '0;
         rleft_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         wrap_ff       <= wrap_in;
         wcur_ff       <= wcur_in;
         wleft_ff      <= wleft_in;
         wwraps_ff     <= wwraps_in;
         rcur_ff       <= rcur_in;
         rleft_ff      <= rleft_in;
         rsp_valid_ff  <= rsp_valid_in;
         hdr_addr_ff   <= hdr_addr_in;
         hdr_byte_ff   <= hdr_byte_in;
         rbase_ff      <= rbase_in;
         lim_ff        <= lim_in;
         res_status_ff <= res_status_in;
         res_len_ff    <= res_len_in;
         res_byte_ff   <= res_byte_in;
         res_last_ff   <= res_last_in;
         if (rsp_load) begin
            rsp_status     <= res_status_ff;
            rsp_length_out <= res_len_ff;
            rsp_byte_out   <= res_byte_ff;
            rsp_last_byte  <= res_last_ff;
         end
      end
   end

endmodule

`default_nettype wire

/* sim/tb_wrapping_record_ring_buffer.sv */
// Self-checking testbench for wrapping_record_ring_buffer: directed rows, then random
// record traffic over several ring capacities, checked against an in-bench predictor.
// Depends on wrrb_pkg and the RTL of wrapping_record_ring_buffer.
`default_nettype none

module tb_wrapping_record_ring_buffer;

   localparam int RING_BYTES  = 4096;
   localparam int MAX_RECORD  = 1024;
   localparam int PHASE_ITEMS = 100;
   localparam int HOLD_CYCLES = 200;
   localparam int TAIL_READS  = 48;

   typedef struct packed {
      logic [wrrb_pkg::STATUS_W-1:0] status;
      logic [wrrb_pkg::LEN_W-1:0]    length;
      logic [wrrb_pkg::BYTE_W-1:0]   data;
      logic                          last;
   } ring_answer_type;

   typedef struct packed {
      wrrb_pkg::command_type          cmd;
      logic [wrrb_pkg::LEN_W-1:0]     len;
      logic [wrrb_pkg::BYTE_W-1:0]    data;
      logic [wrrb_pkg::LIMIT_W-1:0]   limit;
      logic                           typed;
      ring_answer_type                answer;
   } script_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [wrrb_pkg::CMD_W-1:0]      req_command;
   logic [wrrb_pkg::LEN_W-1:0]      req_record_length;
   logic [wrrb_pkg::BYTE_W-1:0]     req_data_byte;
   logic [wrrb_pkg::LIMIT_W-1:0]    req_read_limit;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [wrrb_pkg::STATUS_W-1:0]   rsp_status;
   logic [wrrb_pkg::LEN_W-1:0]      rsp_length_out;
   logic [wrrb_pkg::BYTE_W-1:0]     rsp_byte_out;
   logic                            rsp_last_byte;
   logic                            csr_wr_en;
   logic [wrrb_pkg::CAP_W-1:0]      csr_wr_data;

   wrapping_record_ring_buffer #(
      .RING_BYTES(RING_BYTES),
      .MAX_RECORD(MAX_RECORD)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_record_length(req_record_length),
      .req_data_byte    (req_data_byte),
      .req_read_limit   (req_read_limit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_length_out   (rsp_length_out),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_last_byte    (rsp_last_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #2 clock = ~clock;

   // shadow copy of the ring state
   logic [7:0]  ring_copy [RING_BYTES];
   int unsigned cap_setting;
   int unsigned head_pos, tail_pos, wrap_pos;
   int unsigned fill_pos, fill_left, fill_len;
   bit          fill_wraps;
   int unsigned drain_pos, drain_left;

   ring_answer_type awaited_replies [$];
   script_row_type  script [$];
   ring_answer_type want;

   int unsigned errors = 0;
   int unsigned transfers_in = 0;
   int unsigned cap_writes = 0;
   int unsigned wraps_taken = 0;
   int unsigned tally [8];
   bit          calm_phase = 1'b0;
   bit          hold_request = 1'b0;

   int unsigned phase_caps [8] = '{4, 16, 37, 64, 150, 0, 4096, 8191};

   function automatic int unsigned usable_bytes();
      return (cap_setting > RING_BYTES) ? RING_BYTES : cap_setting;
   endfunction

   function automatic logic [7:0] store_get(input int unsigned addr);
      return (addr < RING_BYTES) ? ring_copy[addr] : 8'h00;
   endfunction

   function automatic void store_put(input int unsigned addr, input logic [7:0] v);
      if (addr < RING_BYTES)
         ring_copy[addr] = v;
   endfunction

   function automatic void clear_ring();
      head_pos   = 0;
      tail_pos   = 0;
      wrap_pos   = usable_bytes();
      fill_pos   = 0;
      fill_left  = 0;
      fill_wraps = 1'b0;
      fill_len   = 0;
      drain_pos  = 0;
      drain_left = 0;
   endfunction

   // tail only moves once the whole payload is in
   function automatic void commit_record();
      if (fill_wraps) begin
         wrap_pos = tail_pos;
         tail_pos = 0;
         wraps_taken++;
      end
      tail_pos += wrrb_pkg::HEADER_LEN + fill_len;
      fill_wraps = 1'b0;
   endfunction

   function automatic ring_answer_type ring_advance(
         input wrrb_pkg::command_type cmd,
         input logic [wrrb_pkg::LEN_W-1:0] len,
         input logic [wrrb_pkg::BYTE_W-1:0] dbyte,
         input logic [wrrb_pkg::LIMIT_W-1:0] limit);
      ring_answer_type a;
      int unsigned     rec, rlen, base;
      bit              wrapped, at_tail, after_wrap;
      a = '0;
      a.status = wrrb_pkg::STS_IGNORED;
      case (cmd)
         wrrb_pkg::CMD_WRITE_START: begin
            fill_left  = 0;
            fill_wraps = 1'b0;
            if (32'(len) > MAX_RECORD) begin
               a.status = wrrb_pkg::STS_OVERSIZE;
            end else begin
               rec = wrrb_pkg::HEADER_LEN + 32'(len);
               if (head_pos == tail_pos) begin
                  head_pos = 0;
                  tail_pos = 0;
                  wrap_pos = usable_bytes();
               end
               wrapped = head_pos > tail_pos;
               if (wrapped)
                  at_tail = tail_pos + rec < head_pos;
               else
                  at_tail = tail_pos + rec <= usable_bytes();
               after_wrap = !wrapped && rec < head_pos;
               if (at_tail || after_wrap) begin
                  base = at_tail ? tail_pos : 0;
                  fill_wraps = !at_tail;
                  store_put(base, len[7:0]);
                  store_put(base + 1, {5'b0, len[10:8]});
                  fill_pos  = base + wrrb_pkg::HEADER_LEN;
                  fill_left = 32'(len);
                  fill_len  = 32'(len);
                  if (fill_len == 0)
                     commit_record();
                  a.status = wrrb_pkg::STS_OK;
               end else begin
                  a.status = wrrb_pkg::STS_NO_ROOM;
               end
            end
         end
         wrrb_pkg::CMD_WRITE_BYTE: begin
            if (fill_left != 0) begin
               store_put(fill_pos, dbyte);
               fill_pos++;
               fill_left--;
               if (fill_left == 0)
                  commit_record();
               a.status = wrrb_pkg::STS_OK;
            end
         end
         wrrb_pkg::CMD_READ_START: begin
            drain_left = 0;
            if (head_pos == tail_pos) begin
               a.status = wrrb_pkg::STS_EMPTY;
            end else begin
               if (head_pos >= wrap_pos) begin
                  head_pos = 0;
                  wrap_pos = usable_bytes();
               end
               rlen = 32'({store_get(head_pos + 1), store_get(head_pos)});
               if (rlen > 32'(limit)) begin
                  a.status = wrrb_pkg::STS_TOO_LARGE;
               end else begin
                  a.status   = wrrb_pkg::STS_OK;
                  a.length   = rlen[wrrb_pkg::LEN_W-1:0];
                  drain_pos  = head_pos + wrrb_pkg::HEADER_LEN;
                  drain_left = rlen;
                  if (rlen == 0)
                     head_pos = drain_pos;
               end
            end
         end
         default: begin
            if (drain_left != 0) begin
               a.data = store_get(drain_pos);
               drain_pos++;
               drain_left--;
               if (drain_left == 0) begin
                  a.last   = 1'b1;
                  head_pos = drain_pos;
               end
               a.status = wrrb_pkg::STS_OK;
            end
         end
      endcase
      return a;
   endfunction

   task automatic add_row(input wrrb_pkg::command_type cmd, input int len, input int data,
                          input int limit, input bit typed,
                          input logic [wrrb_pkg::STATUS_W-1:0] status, input int length);
      script_row_type r;
      r.cmd           = cmd;
      r.len           = len[wrrb_pkg::LEN_W-1:0];
      r.data          = data[wrrb_pkg::BYTE_W-1:0];
      r.limit         = limit[wrrb_pkg::LIMIT_W-1:0];
      r.typed         = typed;
      r.answer        = '0;
      r.answer.status = status;
      r.answer.length = length[wrrb_pkg::LEN_W-1:0];
      script.push_back(r);
   endtask

   // offer one item, hold it until the transfer, then record what should come back
   task automatic transfer_item(input wrrb_pkg::command_type cmd,
                                input logic [wrrb_pkg::LEN_W-1:0] len,
                                input logic [wrrb_pkg::BYTE_W-1:0] data,
                                input logic [wrrb_pkg::LIMIT_W-1:0] limit,
                                input bit typed, input ring_answer_type typed_answer);
      ring_answer_type predicted;
      int              gap;
      if (!calm_phase && $urandom_range(0, 99) < 8) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_record_length <= len;
      req_data_byte     <= data;
      req_read_limit    <= limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = ring_advance(cmd, len, data, limit);
      awaited_replies.push_back(typed ? typed_answer : predicted);
      transfers_in++;
   endtask

   task automatic write_capacity(input int unsigned value);
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[wrrb_pkg::CAP_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = value;
      clear_ring();
      cap_writes++;
   endtask

   // mostly well-formed record traffic; write_share biases fill against drain
   task automatic random_item(input int write_share);
      wrrb_pkg::command_type          cmd;
      logic [wrrb_pkg::LEN_W-1:0]     len;
      logic [wrrb_pkg::LIMIT_W-1:0]   limit;
      int                             pick, sel;
      pick = $urandom_range(0, 99);
      if (fill_left != 0 && (drain_left == 0 || $urandom_range(0, 1) == 1)) begin
         if (pick < 90)      cmd = wrrb_pkg::CMD_WRITE_BYTE;
         else if (pick < 94) cmd = wrrb_pkg::CMD_WRITE_START;
         else if (pick < 97) cmd = wrrb_pkg::CMD_READ_START;
         else                cmd = wrrb_pkg::CMD_READ_BYTE;
      end else if (drain_left != 0) begin
         if (pick < 90)      cmd = wrrb_pkg::CMD_READ_BYTE;
         else if (pick < 95) cmd = wrrb_pkg::CMD_READ_START;
         else                cmd = wrrb_pkg::CMD_WRITE_START;
      end else begin
         if (pick < write_share) cmd = wrrb_pkg::CMD_WRITE_START;
         else if (pick < 93)     cmd = wrrb_pkg::CMD_READ_START;
         else if (pick < 97)     cmd = wrrb_pkg::CMD_WRITE_BYTE;
         else                    cmd = wrrb_pkg::CMD_READ_BYTE;
      end
      sel = $urandom_range(0, 99);
      if (sel < 65)      len = wrrb_pkg::LEN_W'($urandom_range(0, 8));
      else if (sel < 88) len = wrrb_pkg::LEN_W'($urandom_range(0, 40));
      else if (sel < 96) len = wrrb_pkg::LEN_W'($urandom_range(41, 300));
      else               len = wrrb_pkg::LEN_W'($urandom_range(MAX_RECORD + 1, 2047));
      if ($urandom_range(0, 99) < 85)
         limit = wrrb_pkg::LIMIT_W'($urandom_range(1024, 65535));
      else
         limit = wrrb_pkg::LIMIT_W'($urandom_range(0, 24));
      transfer_item(cmd, len, 8'($urandom_range(0, 255)), limit, 1'b0, '0);
   endtask

   task automatic check_field(input string what, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (got_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, got status %0d",
                     $time, rsp_status);
         end else begin
            want = awaited_replies.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("length_out", 16'(want.length), 16'(rsp_length_out));
            check_field("byte_out", 16'(want.data), 16'(rsp_byte_out));
            check_field("last_byte", 16'(want.last), 16'(rsp_last_byte));
            tally[rsp_status]++;
         end
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
         end
         rsp_stall <= !calm_phase && ($urandom_range(0, 99) < 8);
      end
   end

   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int unsigned cap;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = wrrb_pkg::CMD_WRITE_START;
      req_record_length = '0;
      req_data_byte     = '0;
      req_read_limit    = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      cap_setting       = 32'(wrrb_pkg::CAP_RESET);
      clear_ring();

      // cmd, len, data, limit, typed, status, length
      add_row(wrrb_pkg::CMD_READ_START,     0,   0, 65535, 1'b1, wrrb_pkg::STS_EMPTY,     0);
      add_row(wrrb_pkg::CMD_WRITE_BYTE,     0, 255,     0, 1'b1, wrrb_pkg::STS_IGNORED,   0);
      add_row(wrrb_pkg::CMD_READ_BYTE,      0,   0,     0, 1'b1, wrrb_pkg::STS_IGNORED,   0);
      add_row(wrrb_pkg::CMD_WRITE_START, 2047,   0,     0, 1'b1, wrrb_pkg::STS_OVERSIZE,  0);
      add_row(wrrb_pkg::CMD_WRITE_START, 1025,   0,     0, 1'b1, wrrb_pkg::STS_OVERSIZE,  0);
      add_row(wrrb_pkg::CMD_WRITE_START,    0,   0,     0, 1'b1, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_READ_START,     0,   0,     0, 1'b1, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_READ_START,     0,   0,     0, 1'b1, wrrb_pkg::STS_EMPTY,     0);
      add_row(wrrb_pkg::CMD_WRITE_START, 1024,   0,     0, 1'b1, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_WRITE_BYTE,     0,   0,     0, 1'b1, wrrb_pkg::STS_OK,        0);
      // restart abandons the half-written record
      add_row(wrrb_pkg::CMD_WRITE_START,    3,   0,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      // nothing visible before the last payload byte
      add_row(wrrb_pkg::CMD_READ_START,     0,   0, 65535, 1'b1, wrrb_pkg::STS_EMPTY,     0);
      add_row(wrrb_pkg::CMD_WRITE_BYTE,     0,   0,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_WRITE_BYTE,     0, 255,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_WRITE_BYTE,     0,  90,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_WRITE_BYTE,     0,  17,     0, 1'b1, wrrb_pkg::STS_IGNORED,   0);
      add_row(wrrb_pkg::CMD_READ_START,     0,   0,     2, 1'b1, wrrb_pkg::STS_TOO_LARGE, 0);
      add_row(wrrb_pkg::CMD_READ_START,     0,   0,     3, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_READ_BYTE,      0,   0,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      // restarted read goes back to the first byte
      add_row(wrrb_pkg::CMD_READ_START,     0,   0, 65535, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_READ_BYTE,      0,   0,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_READ_BYTE,      0,   0,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_READ_BYTE,      0,   0,     0, 1'b0, wrrb_pkg::STS_OK,        0);
      add_row(wrrb_pkg::CMD_READ_BYTE,      0,   0,     0, 1'b1, wrrb_pkg::STS_IGNORED,   0);
      add_row(wrrb_pkg::CMD_READ_START,     0,   0, 65535, 1'b1, wrrb_pkg::STS_EMPTY,     0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         transfer_item(script[i].cmd, script[i].len, script[i].data, script[i].limit,
                       script[i].typed, script[i].answer);

      for (int p = 0; p < 8; p++) begin
         cap = (phase_caps[p] == 0) ? $urandom_range(5, 600) : phase_caps[p];
         write_capacity(cap);
         calm_phase = (p == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 40)
               hold_request = 1'b1;
            random_item((p % 2 == 1) ? 62 : 45);
         end
      end
      calm_phase = 1'b0;

      // largest record filling the ring exactly
      write_capacity(MAX_RECORD + wrrb_pkg::HEADER_LEN);
      transfer_item(wrrb_pkg::CMD_WRITE_START, wrrb_pkg::LEN_W'(MAX_RECORD), 8'h00,
                    16'd0, 1'b0, '0);
      for (int n = 0; n < MAX_RECORD; n++)
         transfer_item(wrrb_pkg::CMD_WRITE_BYTE, wrrb_pkg::LEN_W'($urandom_range(0, 2047)),
                       8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       1'b0, '0);
      transfer_item(wrrb_pkg::CMD_WRITE_START, '0, 8'h00, 16'd0, 1'b0, '0);
      transfer_item(wrrb_pkg::CMD_READ_START, '0, 8'h00, 16'(MAX_RECORD - 1), 1'b0, '0);
      transfer_item(wrrb_pkg::CMD_READ_START, '0, 8'h00, 16'(MAX_RECORD), 1'b0, '0);
      for (int n = 0; n < TAIL_READS; n++)
         transfer_item(wrrb_pkg::CMD_READ_BYTE, wrrb_pkg::LEN_W'($urandom_range(0, 2047)),
                       8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       1'b0, '0);

      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Run: %0d transfers in, %0d capacity writes, %0d records placed after a wrap.",
               transfers_in, cap_writes, wraps_taken);
      $display("Statuses: ok %0d, empty %0d, too large %0d, no room %0d, oversize %0d, ign %0d.",
               tally[wrrb_pkg::STS_OK], tally[wrrb_pkg::STS_EMPTY],
               tally[wrrb_pkg::STS_TOO_LARGE], tally[wrrb_pkg::STS_NO_ROOM],
               tally[wrrb_pkg::STS_OVERSIZE], tally[wrrb_pkg::STS_IGNORED]);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
